/* src/brf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared widths, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int CNT_W  = 11;
  localparam int BYTE_W = 8;
  localparam int BLEN_W = 7;
  localparam int CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // controller -> datapath
  typedef struct packed {
    logic push;      // store push byte (if room) and post its result
    logic clear;     // empty the queue and post its result
    logic single;    // post a no-data result for an empty burst
    logic start;     // burst begins: load read cursor
    logic rd_issue;  // read one byte at the cursor
    logic rd_last;   // this read is the final byte of the burst
    logic pop;       // burst removes the bytes it reads
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             drain_ok;  // read pipe empty and output slot free
    logic             rd_ok;     // a read may be issued this cycle
  } dp_stat_t;

endpackage

/* src/byte_ring_fifo_burst_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst_unit
// Circular byte FIFO with configurable capacity and pop/peek bursts.
// ----------------------------------------------------------------------------
// Push, clear, and a pop or peek that finds nothing to read each give one
// transfer on the output. A pop or peek of n bytes gives n transfers, one
// per cycle from the single-port byte store while the output is not stalled.
// The read cursor is loaded in the accept cycle and the store read is
// registered, so the first byte is read from the store after the cursor is
// loaded and then moves into the output register. The next command is taken
// once the last byte has left the read stage.
// A capacity write empties the queue; the written value is clamped to
// 2..min(DEPTH, 2047). The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module byte_ring_fifo_burst_unit #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brf_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [brf_pkg::CMD_W-1:0]    command_i,
  input  logic [brf_pkg::BYTE_W-1:0]   push_byte_i,
  input  logic [brf_pkg::BLEN_W-1:0]   burst_len_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [brf_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                         byte_valid_o,
  output logic                         last_o,
  output logic                         push_accepted_o,
  output logic [brf_pkg::CNT_W-1:0]    used_count_o,
  output logic [brf_pkg::CNT_W-1:0]    free_count_o
);
  import brf_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  brf_ctrl #(
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .burst_len_i (burst_len_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  brf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .push_byte_i     (push_byte_i),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_o          (last_o),
    .push_accepted_o (push_accepted_o),
    .used_count_o    (used_count_o),
    .free_count_o    (free_count_o)
  );

endmodule

/* src/brf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-port RAM with registered read; read data holds when idle.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/brf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ctrl
// Command decode and burst sequencer: accepts items, counts burst reads.
// ----------------------------------------------------------------------------
module brf_ctrl #(
  parameter int MAX_BURST = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [brf_pkg::CMD_W-1:0]    command_i,
  input  logic [brf_pkg::BLEN_W-1:0]   burst_len_i,
  input  brf_pkg::dp_stat_t            stat_i,
  output brf_pkg::ctrl_cmd_t           cmd_o
);
  import brf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  localparam logic [BLEN_W-1:0] MaxB = BLEN_W'(MAX_BURST);

  state_e             state_q, state_d;
  logic [BLEN_W-1:0]  remain_q, remain_d;
  logic               pop_q, pop_d;
  logic               accept;
  logic [BLEN_W-1:0]  blen_sat;
  logic [BLEN_W-1:0]  n_bytes;

  assign in_ready_o = (state_q == ST_IDLE) && stat_i.drain_ok;
  assign accept     = in_valid_i && in_ready_o;

  assign blen_sat = (burst_len_i > MaxB) ? MaxB : burst_len_i;
  assign n_bytes  = (CNT_W'(blen_sat) < stat_i.fill) ? blen_sat
                                                     : stat_i.fill[BLEN_W-1:0];

  always_comb begin
    state_d  = state_q;
    remain_d = remain_q;
    pop_d    = pop_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_PUSH:  cmd_o.push  = 1'b1;
            CMD_CLEAR: cmd_o.clear = 1'b1;
            default: begin
              if (n_bytes == '0) begin
                cmd_o.single = 1'b1;
              end else begin
                cmd_o.start = 1'b1;
                remain_d    = n_bytes;
                pop_d       = (cmd_e'(command_i) == CMD_POP);
                state_d     = ST_BURST;
              end
            end
          endcase
        end
      end
      ST_BURST: begin
        cmd_o.pop = pop_q;
        if (stat_i.rd_ok) begin
          cmd_o.rd_issue = 1'b1;
          cmd_o.rd_last  = (remain_q == BLEN_W'(1));
          remain_d       = remain_q - BLEN_W'(1);
          if (remain_q == BLEN_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      remain_q <= '0;
      pop_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      remain_q <= remain_d;
      pop_q    <= pop_d;
    end
  end

endmodule

/* src/brf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_datapath
// Ring pointers, fill level, capacity, byte store and output register.
// ----------------------------------------------------------------------------
module brf_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brf_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic [brf_pkg::BYTE_W-1:0]   push_byte_i,
  input  brf_pkg::ctrl_cmd_t           cmd_i,
  output brf_pkg::dp_stat_t            stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [brf_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                         byte_valid_o,
  output logic                         last_o,
  output logic                         push_accepted_o,
  output logic [brf_pkg::CNT_W-1:0]    used_count_o,
  output logic [brf_pkg::CNT_W-1:0]    free_count_o
);
  import brf_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int CAP_LIM = (DEPTH > (2 ** CNT_W - 1)) ? (2 ** CNT_W - 1) : DEPTH;
  localparam int CAP_RST_I = (CAP_LIM < 1024) ? CAP_LIM : 1024;
  localparam logic [CNT_W-1:0] CapMax = CNT_W'(CAP_LIM);
  localparam logic [CNT_W-1:0] CapMin = CNT_W'(2);
  localparam logic [CNT_W-1:0] CapRst = CNT_W'(CAP_RST_I);

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
    logic [CMP_W-1:0] inc;
    inc = CMP_W'(idx) + CMP_W'(1);
    return (inc >= CMP_W'(cap)) ? '0 : inc[IDX_W-1:0];
  endfunction

  logic [CNT_W-1:0]  cap_q;
  logic [IDX_W-1:0]  rd_ptr_q, wr_ptr_q, cursor_q;
  logic [CNT_W-1:0]  fill_q;
  logic              p1_q;
  logic              p1_last_q;
  logic [CNT_W-1:0]  p1_used_q;
  logic              ov_q;
  logic [BYTE_W-1:0] ob_q;
  logic              obv_q, olast_q, oacc_q;
  logic [CNT_W-1:0]  oused_q, ofree_q;

  logic              full;
  logic              slot_free;
  logic              move;
  logic              wr_en;
  logic [IDX_W-1:0]  ram_addr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  cap_wr;

  assign full      = (fill_q >= cap_q);
  assign slot_free = !ov_q || out_ready_i;
  assign move      = p1_q && slot_free;
  assign wr_en     = cmd_i.push && !full;
  assign ram_addr  = cmd_i.push ? wr_ptr_q : cursor_q;
  assign cap_wr    = (cfg_data_i < CapMin) ? CapMin :
                     (cfg_data_i > CapMax) ? CapMax : cfg_data_i;

  assign stat_o.fill     = fill_q;
  assign stat_o.drain_ok = !p1_q && slot_free;
  assign stat_o.rd_ok    = !p1_q || move;

  brf_ram #(
    .Width (BYTE_W),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .re_i    (cmd_i.rd_issue),
    .addr_i  (ram_addr),
    .wdata_i (push_byte_i),
    .rdata_o (ram_rdata)
  );

  // queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CapRst;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cursor_q <= '0;
      fill_q   <= '0;
    end else if (cfg_we_i) begin
      cap_q    <= cap_wr;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cursor_q <= '0;
      fill_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        rd_ptr_q <= '0;
        wr_ptr_q <= '0;
        fill_q   <= '0;
      end
      if (wr_en) begin
        wr_ptr_q <= ring_next(wr_ptr_q, cap_q);
        fill_q   <= fill_q + CNT_W'(1);
      end
      if (cmd_i.start) begin
        cursor_q <= rd_ptr_q;
      end
      if (cmd_i.rd_issue) begin
        cursor_q <= ring_next(cursor_q, cap_q);
        if (cmd_i.pop) begin
          rd_ptr_q <= ring_next(cursor_q, cap_q);
          fill_q   <= fill_q - CNT_W'(1);
        end
      end
    end
  end

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cmd_i.rd_issue) begin
        p1_q <= 1'b1;
      end else if (move) begin
        p1_q <= 1'b0;
      end
      if (cmd_i.push || cmd_i.clear || cmd_i.single || move) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // read stage sideband and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      p1_last_q <= cmd_i.rd_last;
      p1_used_q <= cmd_i.pop ? (fill_q - CNT_W'(1)) : fill_q;
    end
    if (cmd_i.push) begin
      ob_q    <= '0;
      obv_q   <= 1'b0;
      olast_q <= 1'b1;
      oacc_q  <= !full;
      oused_q <= full ? fill_q : (fill_q + CNT_W'(1));
      ofree_q <= full ? (cap_q - fill_q) : (cap_q - fill_q - CNT_W'(1));
    end else if (cmd_i.clear) begin
      ob_q    <= '0;
      obv_q   <= 1'b0;
      olast_q <= 1'b1;
      oacc_q  <= 1'b0;
      oused_q <= '0;
      ofree_q <= cap_q;
    end else if (cmd_i.single) begin
      ob_q    <= '0;
      obv_q   <= 1'b0;
      olast_q <= 1'b1;
      oacc_q  <= 1'b0;
      oused_q <= fill_q;
      ofree_q <= cap_q - fill_q;
    end else if (move) begin
      ob_q    <= ram_rdata;
      obv_q   <= 1'b1;
      olast_q <= p1_last_q;
      oacc_q  <= 1'b0;
      oused_q <= p1_used_q;
      ofree_q <= cap_q - p1_used_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign out_byte_o      = ob_q;
  assign byte_valid_o    = obv_q;
  assign last_o          = olast_q;
  assign push_accepted_o = oacc_q;
  assign used_count_o    = oused_q;
  assign free_count_o    = ofree_q;

endmodule

/* sim/byte_ring_fifo_burst_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst_unit_tb
// Self-checking bench for the byte ring FIFO. A directed pass covers empty
// and zero-length bursts, oversize bursts, a full queue, wraparound and clear.
// Random push/pop/peek/clear traffic then runs at several capacities under
// different stall patterns. Every output transfer is checked against a
// behavioral ring model.
// ----------------------------------------------------------------------------
module byte_ring_fifo_burst_unit_tb;
  import brf_pkg::*;

  localparam int RING_DEPTH  = 1024;
  localparam int BURST_MAX   = 64;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              last;
    logic              accepted;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
  } fifo_result_t;

  class ring_scoreboard;
    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    int unsigned       level;
    int unsigned       cap_reg;
    fifo_result_t      expected_q[$];
    int                mismatches;

    function new();
      cap_reg    = RING_DEPTH;
      mismatches = 0;
      flush();
    endfunction

    function void flush();
      rd_ptr = 0;
      wr_ptr = 0;
      level  = 0;
    endfunction

    function int unsigned cap_eff();
      if (cap_reg < 2) return 2;
      if (cap_reg > RING_DEPTH) return RING_DEPTH;
      return cap_reg;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] value);
      cap_reg = value;
      flush();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_result(logic [BYTE_W-1:0] data, logic valid, logic last,
                             logic accepted, int unsigned used);
      fifo_result_t r;
      r.data     = data;
      r.valid    = valid;
      r.last     = last;
      r.accepted = accepted;
      r.used     = CNT_W'(used);
      r.free     = CNT_W'(cap_eff() - used);
      expected_q.push_back(r);
    endfunction

    // Called once per accepted command transfer.
    function void note_input(cmd_e cmd, logic [BYTE_W-1:0] pbyte,
                             logic [BLEN_W-1:0] blen);
      int unsigned cap;
      int unsigned n;
      int unsigned idx;
      int unsigned used;
      cap = cap_eff();
      case (cmd)
        CMD_PUSH: begin
          if (level < cap) begin
            ring_mem[wr_ptr] = pbyte;
            wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
            level++;
            add_result('0, 1'b0, 1'b1, 1'b1, level);
          end else begin
            add_result('0, 1'b0, 1'b1, 1'b0, level);
          end
        end
        CMD_CLEAR: begin
          flush();
          add_result('0, 1'b0, 1'b1, 1'b0, 0);
        end
        default: begin
          n = (blen > BURST_MAX) ? BURST_MAX : blen;
          if (n > level) n = level;
          if (n == 0) begin
            add_result('0, 1'b0, 1'b1, 1'b0, level);
          end else begin
            idx  = rd_ptr;
            used = level;
            for (int unsigned i = 0; i < n; i++) begin
              if (cmd == CMD_POP) used--;
              add_result(ring_mem[idx], 1'b1, (i + 1 == n), 1'b0, used);
              idx = (idx + 1 >= cap) ? 0 : idx + 1;
            end
            if (cmd == CMD_POP) begin
              rd_ptr = idx;
              level  = used;
            end
          end
        end
      endcase
    endfunction

    function string fmt(fifo_result_t r);
      return $sformatf("byte=%h vld=%b last=%b acc=%b used=%0d free=%0d",
                       r.data, r.valid, r.last, r.accepted, r.used, r.free);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(fifo_result_t got);
      fifo_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch({"unexpected transfer ", fmt(got)});
      end else begin
        want = expected_q.pop_front();
        if (got !== want)
          report_mismatch({"got ", fmt(got), " exp ", fmt(want)});
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CNT_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i;
  logic [BYTE_W-1:0]   push_byte_i;
  logic [BLEN_W-1:0]   burst_len_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [BYTE_W-1:0]   out_byte_o;
  logic                byte_valid_o;
  logic                last_o;
  logic                push_accepted_o;
  logic [CNT_W-1:0]    used_count_o;
  logic [CNT_W-1:0]    free_count_o;

  ring_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;

  byte_ring_fifo_burst_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .push_byte_i     (push_byte_i),
    .burst_len_i     (burst_len_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_o          (last_o),
    .push_accepted_o (push_accepted_o),
    .used_count_o    (used_count_o),
    .free_count_o    (free_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({out_byte_o, byte_valid_o, last_o, push_accepted_o,
                       used_count_o, free_count_o});
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // Entered and left just after a falling edge.
  task automatic send_cmd(cmd_e cmd, logic [BYTE_W-1:0] pbyte,
                          logic [BLEN_W-1:0] blen);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    push_byte_i <= pbyte;
    burst_len_i <= blen;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, pbyte, blen);
    @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_capacity(value);
  endtask

  task automatic run_random(int count, int push_pct);
    int                r;
    int unsigned       hi;
    logic [BLEN_W-1:0] blen;
    cmd_e              cmd;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < push_pct) begin
        cmd = CMD_PUSH;
      end else begin
        r = $urandom_range(99);
        if (r < 45) cmd = CMD_POP;
        else if (r < 90) cmd = CMD_PEEK;
        else cmd = CMD_CLEAR;
      end
      r  = $urandom_range(99);
      hi = (sb.level + 2 > BURST_MAX) ? BURST_MAX : sb.level + 2;
      if (r < 8) blen = '0;
      else if (r < 16) blen = BLEN_W'($urandom_range(127, BURST_MAX + 1));
      else blen = BLEN_W'($urandom_range(hi, 1));
      send_cmd(cmd, BYTE_W'($urandom), blen);
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    command_i      = CMD_PUSH;
    push_byte_i    = '0;
    burst_len_i    = '0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sb = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty queue, extremes of byte and length, oversize pop, clear
    send_cmd(CMD_POP,   8'h00, 7'd5);
    send_cmd(CMD_PEEK,  8'hff, 7'd1);
    send_cmd(CMD_PUSH,  8'h00, 7'd0);
    send_cmd(CMD_PUSH,  8'hff, 7'd127);
    send_cmd(CMD_PUSH,  8'ha5, 7'd1);
    send_cmd(CMD_PUSH,  8'h5a, 7'd64);
    send_cmd(CMD_PEEK,  8'h00, 7'd0);
    send_cmd(CMD_PEEK,  8'h00, 7'd2);
    send_cmd(CMD_POP,   8'h00, 7'd127);
    send_cmd(CMD_PUSH,  8'h3c, 7'd3);
    send_cmd(CMD_CLEAR, 8'h77, 7'd9);
    send_cmd(CMD_POP,   8'h00, 7'd64);

    // below-minimum capacity: full queue, refused push, wraparound
    write_capacity(11'd1);
    send_cmd(CMD_PUSH,  8'h11, 7'd0);
    send_cmd(CMD_PUSH,  8'h22, 7'd0);
    send_cmd(CMD_PUSH,  8'h33, 7'd0);
    send_cmd(CMD_PEEK,  8'h00, 7'd64);
    send_cmd(CMD_POP,   8'h00, 7'd1);
    send_cmd(CMD_PUSH,  8'h44, 7'd0);
    send_cmd(CMD_POP,   8'h00, 7'd64);
    send_cmd(CMD_PEEK,  8'h00, 7'd3);

    write_capacity(11'd2047);
    run_random(35, 75);

    write_capacity(11'd5);
    send_idle_pct = 47;
    run_random(30, 50);

    write_capacity(11'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 47;
    run_random(30, 50);

    write_capacity(11'd1024);
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    run_random(35, 60);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
